// ===== sv/ldf_pkg.sv =====
// Shared constants and result kind codes for the length-prefixed deframer.
package ldf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned SHIFT_W  = 64;

    localparam logic [COUNT_W-1:0] VALIDATION_HEADER_BYTES = 4'd8;
    localparam logic [COUNT_W-1:0] FRAME_HEADER_BYTES      = 4'd4;

    localparam logic [LIMIT_W-1:0] MAX_FIRST_LENGTH_RESET  = 16'd2048;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALIDATION_BYTE  = 3'd0,
        KIND_FRAME_BYTE       = 3'd1,
        KIND_EMPTY_VALIDATION = 3'd2,
        KIND_EMPTY_FRAME      = 3'd3,
        KIND_LENGTH_ERROR     = 3'd4
    } kind_t;

endpackage

// ===== sv/length_prefixed_deframer_core.sv =====
// Length-prefixed byte-stream deframer: header parsing, payload tagging, result register.
//
// Usage:
//   Input channel (in_valid, in_stall, data_byte) carries one stream byte per item.
//   Output channel (out_valid, out_stall, kind, payload_byte, last_in_message,
//   message_type, message_length) carries one tagged payload byte or marker per item.
//   The first message has an 8-byte big-endian header (type, length); later messages
//   have a 4-byte big-endian length. Header bytes give no result. A zero-length message
//   gives one empty marker; a first length above max_first_length gives one
//   length-error result and all later bytes are dropped until reset.
//   Configuration: max_first_length is written on cfg_valid (cfg_ready is always high);
//   the user must write it only while the block is idle; the block does not enforce this.
// Timing:
//   An accepted byte lands in the input register and is parsed into the output register
//   as soon as that register is empty or not stalled. Throughput is one item per cycle
//   unless out_stall holds a result; parsing is one pass of short logic per byte.
// Reset: all control state clears, max_first_length returns to 2048, no result valid.
// Stall: a held result blocks the parser; the input register then fills and in_stall
//   rises in the same cycle, so no byte is lost and the held result stays unchanged.
module length_prefixed_deframer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ldf_pkg::BYTE_W-1:0]           data_byte,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [ldf_pkg::KIND_W-1:0]           kind,
    output logic [ldf_pkg::BYTE_W-1:0]           payload_byte,
    output logic                                 last_in_message,
    output logic [ldf_pkg::WORD_W-1:0]           message_type,
    output logic [ldf_pkg::WORD_W-1:0]           message_length,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ldf_pkg::LIMIT_W-1:0]          max_first_length
);

    // input register
    logic                                s1_valid_reg, s1_valid_next;
    logic [ldf_pkg::BYTE_W-1:0]          s1_byte_reg;

    // parser state
    logic [ldf_pkg::SHIFT_W-1:0]         header_shift_reg, header_shift_next;
    logic [ldf_pkg::COUNT_W-1:0]         header_count_reg, header_count_next;
    logic                                in_payload_reg, in_payload_next;
    logic                                validated_reg, validated_next;
    logic [ldf_pkg::WORD_W-1:0]          bytes_left_reg, bytes_left_next;
    logic [ldf_pkg::WORD_W-1:0]          held_type_reg, held_type_next;
    logic [ldf_pkg::WORD_W-1:0]          held_length_reg, held_length_next;
    logic                                error_flag_reg, error_flag_next;
    logic [ldf_pkg::LIMIT_W-1:0]         limit_reg;

    // result register
    logic                                out_valid_reg, out_valid_next;
    ldf_pkg::kind_t                      kind_reg, kind_next;
    logic [ldf_pkg::BYTE_W-1:0]          byte_reg, byte_next;
    logic                                last_reg, last_next;
    logic [ldf_pkg::WORD_W-1:0]          type_reg;
    logic [ldf_pkg::WORD_W-1:0]          len_reg;

    logic                                advance;
    logic                                fire;
    logic                                emit;
    logic [ldf_pkg::SHIFT_W-1:0]         shift_in;
    logic [ldf_pkg::COUNT_W-1:0]         count_inc;
    logic [ldf_pkg::COUNT_W-1:0]         need;
    logic [ldf_pkg::WORD_W-1:0]          hdr_len;
    logic [ldf_pkg::WORD_W-1:0]          left_dec;

    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    assign s1_valid_next = (in_valid && !in_stall) ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);

    assign shift_in  = {header_shift_reg[ldf_pkg::SHIFT_W-ldf_pkg::BYTE_W-1:0], s1_byte_reg};
    assign count_inc = header_count_reg + 4'd1;
    assign need      = validated_reg ? ldf_pkg::FRAME_HEADER_BYTES
                                     : ldf_pkg::VALIDATION_HEADER_BYTES;
    assign hdr_len   = shift_in[ldf_pkg::WORD_W-1:0];
    assign left_dec  = bytes_left_reg - 32'd1;

    always_comb
    begin
        header_shift_next = header_shift_reg;
        header_count_next = header_count_reg;
        in_payload_next   = in_payload_reg;
        validated_next    = validated_reg;
        bytes_left_next   = bytes_left_reg;
        held_type_next    = held_type_reg;
        held_length_next  = held_length_reg;
        error_flag_next   = error_flag_reg;
        emit              = 1'b0;
        kind_next         = ldf_pkg::KIND_FRAME_BYTE;
        byte_next         = '0;
        last_next         = 1'b1;
        if (fire && !error_flag_reg)
        begin
            if (!in_payload_reg)
            begin
                header_shift_next = shift_in;
                if (count_inc < need)
                begin
                    header_count_next = count_inc;
                end
                else
                begin
                    header_count_next = '0;
                    held_length_next  = hdr_len;
                    if (!validated_reg)
                    begin
                        held_type_next = shift_in[ldf_pkg::SHIFT_W-1:ldf_pkg::WORD_W];
                        if (hdr_len > {16'd0, limit_reg})
                        begin
                            error_flag_next = 1'b1;
                            emit            = 1'b1;
                            kind_next       = ldf_pkg::KIND_LENGTH_ERROR;
                        end
                        else if (hdr_len == '0)
                        begin
                            validated_next = 1'b1;
                            emit           = 1'b1;
                            kind_next      = ldf_pkg::KIND_EMPTY_VALIDATION;
                        end
                        else
                        begin
                            in_payload_next = 1'b1;
                            bytes_left_next = hdr_len;
                        end
                    end
                    else
                    begin
                        held_type_next = '0;
                        if (hdr_len == '0)
                        begin
                            emit      = 1'b1;
                            kind_next = ldf_pkg::KIND_EMPTY_FRAME;
                        end
                        else
                        begin
                            in_payload_next = 1'b1;
                            bytes_left_next = hdr_len;
                        end
                    end
                end
            end
            else
            begin
                emit            = 1'b1;
                kind_next       = validated_reg ? ldf_pkg::KIND_FRAME_BYTE
                                                : ldf_pkg::KIND_VALIDATION_BYTE;
                byte_next       = s1_byte_reg;
                bytes_left_next = left_dec;
                last_next       = (left_dec == '0);
                if (left_dec == '0)
                begin
                    in_payload_next = 1'b0;
                    validated_next  = 1'b1;
                end
            end
        end
    end

    assign out_valid_next = advance ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            header_shift_reg <= '0;
            header_count_reg <= '0;
            in_payload_reg   <= 1'b0;
            validated_reg    <= 1'b0;
            bytes_left_reg   <= '0;
            held_type_reg    <= '0;
            held_length_reg  <= '0;
            error_flag_reg   <= 1'b0;
            limit_reg        <= ldf_pkg::MAX_FIRST_LENGTH_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            header_shift_reg <= header_shift_next;
            header_count_reg <= header_count_next;
            in_payload_reg   <= in_payload_next;
            validated_reg    <= validated_next;
            bytes_left_reg   <= bytes_left_next;
            held_type_reg    <= held_type_next;
            held_length_reg  <= held_length_next;
            error_flag_reg   <= error_flag_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= max_first_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
        end
        if (emit && advance)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            last_reg <= last_next;
            type_reg <= held_type_next;
            len_reg  <= held_length_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign payload_byte    = byte_reg;
    assign last_in_message = last_reg;
    assign message_type    = type_reg;
    assign message_length  = len_reg;

`ifndef SYNTHESIS
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_flag_reg |=> error_flag_reg)
        else $error("length error flag cleared before reset");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (bytes_left_reg != '0) && (header_count_reg == '0))
        else $error("payload phase with no bytes left or partial header");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == ldf_pkg::KIND_EMPTY_VALIDATION
            || kind_reg == ldf_pkg::KIND_EMPTY_FRAME
            || kind_reg == ldf_pkg::KIND_LENGTH_ERROR) |-> last_reg && (byte_reg == '0))
        else $error("marker result not last or carries a byte");

    a_frame_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == ldf_pkg::KIND_FRAME_BYTE
            || kind_reg == ldf_pkg::KIND_EMPTY_FRAME) |-> (type_reg == '0))
        else $error("frame result carries a type word");

    a_no_result_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        $past(error_flag_reg) && error_flag_reg && !$past(out_valid_reg) |-> !out_valid_reg)
        else $error("result produced after length error");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for length_prefixed_deframer_core: byte stream in, tagged bytes out.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        ldf_pkg::kind_t                 kind;
        logic [ldf_pkg::BYTE_W-1:0]     payload;
        logic                           last;
        logic [ldf_pkg::WORD_W-1:0]     mtype;
        logic [ldf_pkg::WORD_W-1:0]     mlen;
    } deframed_t;

    class deframer_scoreboard;
        logic [ldf_pkg::LIMIT_W-1:0] first_limit;
        logic [ldf_pkg::SHIFT_W-1:0] hdr_shift;
        logic [ldf_pkg::COUNT_W-1:0] hdr_count;
        bit                          in_body;
        bit                          past_first;
        bit                          rejected;
        logic [ldf_pkg::WORD_W-1:0]  remaining;
        logic [ldf_pkg::WORD_W-1:0]  cur_type;
        logic [ldf_pkg::WORD_W-1:0]  cur_len;
        deframed_t                   pending_results[$];
        int unsigned                 errors;
        int unsigned                 bytes_noted;
        int unsigned                 results_checked;

        function new();
            first_limit     = ldf_pkg::MAX_FIRST_LENGTH_RESET;
            hdr_shift       = '0;
            hdr_count       = '0;
            in_body         = 1'b0;
            past_first      = 1'b0;
            rejected        = 1'b0;
            remaining       = '0;
            cur_type        = '0;
            cur_len         = '0;
            errors          = 0;
            bytes_noted     = 0;
            results_checked = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void note_limit(logic [ldf_pkg::LIMIT_W-1:0] v);
            first_limit = v;
        endfunction

        function void push(ldf_pkg::kind_t k, logic [ldf_pkg::BYTE_W-1:0] p, logic l);
            deframed_t r;
            r.kind    = k;
            r.payload = p;
            r.last    = l;
            r.mtype   = cur_type;
            r.mlen    = cur_len;
            pending_results.push_back(r);
        endfunction

        function void deframe_byte(logic [ldf_pkg::BYTE_W-1:0] b);
            logic [ldf_pkg::COUNT_W-1:0] need;
            bytes_noted++;
            if (rejected)
                return;
            if (!in_body)
            begin
                need = past_first ? ldf_pkg::FRAME_HEADER_BYTES
                                  : ldf_pkg::VALIDATION_HEADER_BYTES;
                hdr_shift = {hdr_shift[ldf_pkg::SHIFT_W-ldf_pkg::BYTE_W-1:0], b};
                hdr_count = hdr_count + 1'b1;
                if (hdr_count < need)
                    return;
                hdr_count = '0;
                if (!past_first)
                begin
                    cur_type = hdr_shift[63:32];
                    cur_len  = hdr_shift[31:0];
                    if (cur_len > {16'h0, first_limit})
                    begin
                        rejected = 1'b1;
                        push(ldf_pkg::KIND_LENGTH_ERROR, '0, 1'b1);
                        return;
                    end
                    if (cur_len == '0)
                    begin
                        past_first = 1'b1;
                        push(ldf_pkg::KIND_EMPTY_VALIDATION, '0, 1'b1);
                        return;
                    end
                end
                else
                begin
                    cur_type = '0;
                    cur_len  = hdr_shift[31:0];
                    if (cur_len == '0)
                    begin
                        push(ldf_pkg::KIND_EMPTY_FRAME, '0, 1'b1);
                        return;
                    end
                end
                in_body   = 1'b1;
                remaining = cur_len;
            end
            else
            begin
                remaining = remaining - 1'b1;
                push(past_first ? ldf_pkg::KIND_FRAME_BYTE : ldf_pkg::KIND_VALIDATION_BYTE,
                     b, remaining == '0);
                if (remaining == '0)
                begin
                    in_body    = 1'b0;
                    past_first = 1'b1;
                end
            end
        endfunction

        function void check_output(logic [ldf_pkg::KIND_W-1:0] k,
                                   logic [ldf_pkg::BYTE_W-1:0] p, logic l,
                                   logic [ldf_pkg::WORD_W-1:0] t,
                                   logic [ldf_pkg::WORD_W-1:0] n);
            deframed_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected item: kind %0d payload_byte %02h", k, p);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            results_checked++;
            if (k !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, k);
                errors++;
            end
            if (p !== e.payload)
            begin
                $error("payload_byte: expected %02h, got %02h", e.payload, p);
                errors++;
            end
            if (l !== e.last)
            begin
                $error("last_in_message: expected %0b, got %0b", e.last, l);
                errors++;
            end
            if (t !== e.mtype)
            begin
                $error("message_type: expected %08h, got %08h", e.mtype, t);
                errors++;
            end
            if (n !== e.mlen)
            begin
                $error("message_length: expected %08h, got %08h", e.mlen, n);
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [ldf_pkg::BYTE_W-1:0]   data_byte = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [ldf_pkg::KIND_W-1:0]   kind;
    logic [ldf_pkg::BYTE_W-1:0]   payload_byte;
    logic                         last_in_message;
    logic [ldf_pkg::WORD_W-1:0]   message_type;
    logic [ldf_pkg::WORD_W-1:0]   message_length;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [ldf_pkg::LIMIT_W-1:0]  max_first_length = ldf_pkg::MAX_FIRST_LENGTH_RESET;

    deframer_scoreboard sb = new();
    int unsigned        frames_sent = 0;
    int unsigned        limit_writes = 0;

    length_prefixed_deframer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .last_in_message (last_in_message),
        .message_type    (message_type),
        .message_length  (message_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .max_first_length(max_first_length)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // no idling on either side for a stretch of the stream
    function automatic bit take_break();
        if (sb.bytes_noted >= 300 && sb.bytes_noted < 450)
            return 1'b0;
        return $urandom_range(0, 99) < 20;
    endfunction

    always @(negedge clk)
        out_stall <= take_break();

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.deframe_byte(data_byte);
        if (rst_n && cfg_valid && cfg_ready)
            sb.note_limit(max_first_length);
        if (rst_n && out_valid && !out_stall)
            sb.check_output(kind, payload_byte, last_in_message, message_type, message_length);
    end

    task automatic send_byte(input logic [ldf_pkg::BYTE_W-1:0] b);
        @(negedge clk);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_word(input logic [ldf_pkg::WORD_W-1:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(w[8*i +: 8]);
    endtask

    task automatic send_frame(input logic [ldf_pkg::WORD_W-1:0] len);
        send_word(len);
        repeat (len)
            send_byte(8'($urandom));
        frames_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // header bytes give no item, let the pipeline settle
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [ldf_pkg::LIMIT_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_valid        <= 1'b1;
        max_first_length <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limit_writes++;
    endtask

    initial
    begin
        int unsigned                  path;
        int unsigned                  roll;
        int unsigned                  phase_mark;
        int unsigned                  rot;
        int unsigned                  guard;
        logic [ldf_pkg::LIMIT_W-1:0]  limit;
        logic [ldf_pkg::WORD_W-1:0]   len;
        string                        first_desc;

        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first message outcome: over-long, empty, or a payload right at the limit
        path = $urandom_range(0, 9);
        if (path < 2)
        begin
            limit = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            write_limit(limit);
            len = $urandom;
            if ($urandom_range(0, 1) || len <= {16'h0, limit})
                len = {16'h0, limit} + 1;
            send_word($urandom);
            send_word(len);
            first_desc = "rejected as over-long";
            write_limit(16'($urandom));
            // everything after the error is dropped
            repeat (942)
                send_byte(8'($urandom));
        end
        else
        begin
            if (path == 2)
            begin
                write_limit(16'h0000);
                send_word($urandom);
                send_word(32'h0);
                first_desc = "empty";
            end
            else
            begin
                limit = 16'($urandom_range(1, 24));
                write_limit(limit);
                send_word($urandom);
                send_word({16'h0, limit});
                repeat (limit)
                    send_byte(8'($urandom));
                first_desc = "payload at the limit";
            end

            send_frame(32'h0);
            send_word(32'h1);
            send_byte(8'hFF);
            send_word(32'h2);
            send_byte(8'h00);
            send_byte(8'hA5);
            send_word(32'h3);
            send_byte(8'h5A);
            send_byte(8'hFF);
            send_byte(8'h00);
            frames_sent += 3;
            write_limit(16'hFFFF);

            phase_mark = sb.bytes_noted;
            rot = 0;
            while (sb.bytes_noted < 920)
            begin
                if (sb.bytes_noted - phase_mark >= 200)
                begin
                    case (rot % 4)
                        0: write_limit(16'h0000);
                        1: write_limit(16'($urandom));
                        2: write_limit(ldf_pkg::MAX_FIRST_LENGTH_RESET);
                        default: write_limit(16'hFFFF);
                    endcase
                    rot++;
                    phase_mark = sb.bytes_noted;
                end
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    len = 32'h0;
                else if (roll < 85)
                    len = $urandom_range(1, 12);
                else
                    len = $urandom_range(13, 64);
                send_frame(len);
            end

            // huge frame, never completed
            send_word(32'h8000_0000 | $urandom);
            repeat (24)
                send_byte(8'($urandom));
            frames_sent++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8)
            @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected items never arrived", sb.pending());
            sb.errors++;
        end

        $display("Run: %0d stream bytes, %0d output items checked, %0d frames",
                 sb.bytes_noted, sb.results_checked, frames_sent);
        $display("after a first message %s; limit register written %0d times.",
                 first_desc, limit_writes);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
